/* sv/pprm_pkg.sv */
package pprm_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int CAP_W      = 16;
    localparam int LOW_W      = 16;
    localparam int HIGH_W     = 17;
    localparam int RATE_W     = 24;
    localparam int AVG_W      = 17;
    localparam int SUM_W      = 20;
    localparam int WRAP_W     = 2;
    localparam int PERIOD_W   = 19;  // signed, covers -65535 .. 3*65536+65535
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // divider sizes: widest dividend is the rate numerator, widest divisor the average
    localparam int DIV_DVD_W = RATE_W;
    localparam int DIV_DVS_W = AVG_W;

    localparam int NUM_PERIODS_DEF = 5;

    localparam logic [LOW_W-1:0]  LOW_LIMIT_RST  = LOW_W'(9000);
    localparam logic [HIGH_W-1:0] HIGH_LIMIT_RST = HIGH_W'(40960);
    localparam logic [RATE_W-1:0] RATE_NUM_RST   = RATE_W'(16384 * 600);

    localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_WRAP    = 2'd1,
        OP_CAPTURE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT  = 2'd0,
        CFG_HIGH_LIMIT = 2'd1,
        CFG_RATE_NUM   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AVG,
        ST_RATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             fire;
        logic [SUM_W-1:0] sum_next;
    } t_acc_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* sv/pprm_in_if.sv */
interface pprm_in_if import pprm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [CAP_W-1:0] capture_value;

    modport source (output valid, output operation, output capture_value, input ready);
    modport sink   (input valid, input operation, input capture_value, output ready);
endinterface

/* sv/pprm_out_if.sv */
interface pprm_out_if import pprm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [AVG_W-1:0]  average_period;
    logic [RATE_W-1:0] pulse_rate_tenths;

    modport source (output valid, output average_period, output pulse_rate_tenths, input ready);
    modport sink   (input valid, input average_period, input pulse_rate_tenths, output ready);
endinterface

/* sv/pprm_acc.sv */
module pprm_acc import pprm_pkg::*; #(
    parameter int NUM_PERIODS = NUM_PERIODS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CAP_W-1:0]  i_cap,
    input  logic [LOW_W-1:0]  i_low,
    input  logic [HIGH_W-1:0] i_high,
    output t_acc_stat         o_stat
);

    localparam int CNT_W = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_PERIODS - 1);

    logic [CAP_W-1:0]  r_first, n_first;
    logic              r_have, n_have;
    logic [WRAP_W-1:0] r_wrap, n_wrap;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_done, n_done;

    logic signed [PERIOD_W-1:0] period;
    logic                       in_range;
    logic [SUM_W-1:0]           sum_add;
    logic                       fire;

    // period = second - first + 65536 per wrap
    assign period = $signed({{(PERIOD_W-CAP_W){1'b0}}, i_cap})
                  - $signed({{(PERIOD_W-CAP_W){1'b0}}, r_first})
                  + $signed({1'b0, r_wrap, {CAP_W{1'b0}}});

    assign in_range = (period >= $signed({{(PERIOD_W-LOW_W){1'b0}}, i_low}))
                   && (period <= $signed({{(PERIOD_W-HIGH_W){1'b0}}, i_high}));

    assign sum_add = r_sum + {{(SUM_W-PERIOD_W){1'b0}}, unsigned'(period)};

    always_comb begin
        n_first = r_first;
        n_have  = r_have;
        n_wrap  = r_wrap;
        n_count = r_count;
        n_sum   = r_sum;
        n_done  = r_done;
        fire    = 1'b0;
        if (i_take) begin
            case (t_op'(i_op))
                OP_START: begin
                    n_have  = 1'b0;
                    n_wrap  = '0;
                    n_count = '0;
                    n_sum   = '0;
                    n_done  = 1'b0;
                end
                OP_WRAP: begin
                    if (!r_done && r_wrap != WRAP_MAX) begin
                        n_wrap = r_wrap + WRAP_W'(1);
                    end
                end
                OP_CAPTURE: begin
                    if (!r_done) begin
                        if (!r_have) begin
                            n_first = i_cap;
                            n_have  = 1'b1;
                            n_wrap  = '0;
                        end else begin
                            n_have = 1'b0;
                            if (in_range) begin
                                n_sum = sum_add;
                                if (r_count == CNT_LAST) begin
                                    n_count = '0;
                                    n_done  = 1'b1;
                                    fire    = 1'b1;
                                end else begin
                                    n_count = r_count + CNT_W'(1);
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_wrap  <= '0;
            r_count <= '0;
            r_done  <= 1'b1;
        end else begin
            r_have  <= n_have;
            r_wrap  <= n_wrap;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_first <= n_first;
        r_sum   <= n_sum;
    end

    assign o_stat.fire     = fire;
    assign o_stat.sum_next = sum_add;

endmodule

/* sv/pprm_div.sv */
module pprm_div import pprm_pkg::*; #(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVD_W-1:0] r_quo, n_quo;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] shifted;

    // restoring step: dividend bits leave at the top of r_quo, quotient bits enter at the bottom
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // a zero divisor is forced through every trial, giving an all-ones quotient
            if (!trial[DVS_W] || r_dvs == '0) begin
                n_rem = trial[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

/* sv/pulse_period_rate_meter.sv */
// Pulse period rate meter. Input words are timer events: start, 16-bit counter wrap, or a
// rising-edge capture with its timer value. Captures pair up without overlap; each period is
// the second capture minus the first plus 65536 per wrap seen in between (wrap count saturates
// at 3). Periods within [low_limit, high_limit] are summed; after NUM_PERIODS of them the
// block emits one output word with the truncated average period and the rate in tenths per
// minute (rate_numerator / average, all ones when the average is zero), then ignores wraps and
// captures until the next start. Timing: the input is ready whenever the sequencer is idle. The
// word that completes a measurement starts the bit-serial restoring divider, which runs twice,
// one quotient bit per cycle (average, then rate); the input is held off while it runs, and
// longer if the previous output word has not yet been taken by the sink. The output word sits
// in its own register, so the final result may wait for the sink while new words are already
// accepted. Configuration writes are taken at any cycle, but are meant to happen only while the
// block is idle.
module pulse_period_rate_meter import pprm_pkg::*; #(
    parameter int NUM_PERIODS = NUM_PERIODS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pprm_in_if.sink               i_in,
    pprm_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [LOW_W-1:0]  r_low_limit;
    logic [HIGH_W-1:0] r_high_limit;
    logic [RATE_W-1:0] r_rate_num;

    // sequencer
    t_state r_state, n_state;

    // output word register
    logic              r_out_valid, n_out_valid;
    logic [AVG_W-1:0]  r_out_avg, n_out_avg;
    logic [RATE_W-1:0] r_out_rate, n_out_rate;

    // average held while the rate division runs
    logic [AVG_W-1:0]  r_avg, n_avg;

    t_acc_stat          acc_stat;
    t_div_stat          div_stat;
    logic               take;
    logic               div_start;
    logic [DIV_DVD_W-1:0] div_dividend;
    logic [DIV_DVS_W-1:0] div_divisor;
    logic [DIV_DVD_W-1:0] div_q;

    // words are taken only while the sequencer is idle, not while a result is computed or waits to be loaded
    assign i_in.ready = (r_state == ST_IDLE);
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
            r_rate_num   <= RATE_NUM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data[LOW_W-1:0];
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data[HIGH_W-1:0];
                CFG_RATE_NUM:   r_rate_num   <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pprm_acc #(
        .NUM_PERIODS (NUM_PERIODS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_op    (i_in.operation),
        .i_cap   (i_in.capture_value),
        .i_low   (r_low_limit),
        .i_high  (r_high_limit),
        .o_stat  (acc_stat)
    );

    // first pass divides the sum by the period count, second the numerator by the average
    assign div_dividend = (r_state == ST_IDLE)
                        ? {{(DIV_DVD_W-SUM_W){1'b0}}, acc_stat.sum_next}
                        : r_rate_num;
    assign div_divisor  = (r_state == ST_IDLE) ? DIV_DVS_W'(NUM_PERIODS)
                                               : div_q[AVG_W-1:0];

    pprm_div #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state     = r_state;
        n_avg       = r_avg;
        n_out_avg   = r_out_avg;
        n_out_rate  = r_out_rate;
        n_out_valid = r_out_valid && !o_out.ready;
        div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc_stat.fire) begin
                    div_start = 1'b1;
                    n_state   = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_stat.done) begin
                    // average is the low 17 bits of the quotient
                    n_avg     = div_q[AVG_W-1:0];
                    div_start = 1'b1;
                    n_state   = ST_RATE;
                end
            end
            ST_RATE: begin
                if (div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // load once the previous word has left
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_rate  = div_q[RATE_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_avg      <= n_avg;
        r_out_avg  <= n_out_avg;
        r_out_rate <= n_out_rate;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.average_period    = r_out_avg;
    assign o_out.pulse_rate_tenths = r_out_rate;

    // divider is never restarted while a pass is still running
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a completed measurement can only come from a word taken in idle
    a_fire_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_stat.fire |-> (take && r_state == ST_IDLE))
        else $error("measurement completed outside idle");

    // input stays held off while the divider runs
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !i_in.ready)
        else $error("input accepted during division");

    // a new output word appears only from the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("output word loaded outside output state");

endmodule
